// File: rtl/core/tlsm_pkg.sv
// tick latency stats monitor package: sequencer state type, opcodes and
// register reset values; used by tick_latency_stats_monitor
`timescale 1ns / 1ps
package tlsm_pkg;

	localparam int TIME_W = 32;
	localparam int MIN_W  = 31;

	localparam logic [1:0] OP_RECORD     = 2'd0;
	localparam logic [1:0] OP_ACCUMULATE = 2'd1;
	localparam logic [1:0] OP_FLUSH      = 2'd2;

	localparam logic [MIN_W-1:0] MIN_ELAPSED_RESET = 31'd10;

	typedef enum logic [5:0] {
		ST_CLEAR = 6'b000001,
		ST_IDLE  = 6'b000010,
		ST_SCAN  = 6'b000100,
		ST_DIV   = 6'b001000,
		ST_FIN   = 6'b010000,
		ST_PUSH  = 6'b100000
	} state_t;

endpackage

// File: rtl/core/tick_latency_stats_monitor.sv
// tick latency stats monitor top level: ring memory, window rescan and one
// shared serial divider under a small sequencer; depends on tlsm_pkg
`timescale 1ns / 1ps
// Usage:
// - input channel (in_valid / in_stall) carries opcode, start_time, now_time;
//   output channel (out_valid / out_stall) returns one result per request
// - cfg_wr_en / cfg_wr_data write min_elapsed; write only while idle
// - one request at a time: in_stall is high from acceptance until the result
//   is loaded into the output register
// - record that enters the ring: its result waits for the ring rescan at one
//   memory read per cycle; the average is a shift, or at a depth that is not
//   a power of two a further 32 + clog2(WINDOW_DEPTH) divider steps
// - flush with a nonzero count: 32 + clog2(WINDOW_DEPTH) divider steps
// - other requests go straight to the output register
// - reset: a clearing pass zeroes the ring; requests are stalled during it,
//   min_elapsed returns to 10
// - a stalled result stays in the output register; the next request can be
//   taken meanwhile and waits for the register to free before its result loads
module tick_latency_stats_monitor #(
	parameter int WINDOW_DEPTH = 128
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [30:0] cfg_wr_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  opcode,
	input  logic [31:0] start_time,
	input  logic [31:0] now_time,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] last_elapsed,
	output logic [31:0] window_average,
	output logic [31:0] window_peak,
	output logic        period_valid,
	output logic [31:0] period_average,
	output logic [31:0] period_peak
);

	localparam int AW    = $clog2(WINDOW_DEPTH);
	localparam int CW    = AW + 1;
	localparam int SW    = tlsm_pkg::TIME_W + AW;
	localparam int DCW   = $clog2(SW);
	localparam int TW    = tlsm_pkg::TIME_W;
	localparam bit DEPTH_POW2 = (WINDOW_DEPTH == (1 << AW));

	tlsm_pkg::state_t state_q;

	logic [tlsm_pkg::MIN_W-1:0] min_elapsed_q;
	logic [TW-1:0] ring_mem [WINDOW_DEPTH];
	logic [TW-1:0] rd_q;
	logic          rd_vld_q;
	logic [AW-1:0] wptr_q;
	logic [CW-1:0] cnt_q;
	logic [SW-1:0] sum_q;
	logic [TW-1:0] last_q, wavg_q, wmax_q, pmax_q, ptotal_q, pcount_q;
	logic          pv_q;
	logic [TW-1:0] pavg_q, ppk_q;
	logic          div_win_q;
	logic [DCW-1:0] div_cnt_q;
	logic [TW-1:0] rem_q;
	logic [SW-1:0] quo_q;
	logic [TW-1:0] dvs_q;

	logic          accept;
	logic [TW-1:0] elapsed;
	logic          new_qual, last_qual;
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [TW-1:0] mem_wdata;
	logic [TW:0]   div_shift;
	logic          div_ge;
	logic [TW:0]   div_diff;
	logic          out_free;

	assign in_stall  = (state_q != tlsm_pkg::ST_IDLE);
	assign accept    = in_valid && !in_stall;
	assign elapsed   = now_time - start_time;
	assign new_qual  = !elapsed[TW-1] && (elapsed[TW-2:0] >= min_elapsed_q);
	assign last_qual = !last_q[TW-1] && (last_q[TW-2:0] >= min_elapsed_q);
	assign out_free  = !out_valid || !out_stall;

	// shared restoring divider step
	assign div_shift = {rem_q, quo_q[SW-1]};
	assign div_ge    = (div_shift >= {1'b0, dvs_q});
	assign div_diff  = div_shift - {1'b0, dvs_q};

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = wptr_q;
		mem_wdata = elapsed;
		if (state_q == tlsm_pkg::ST_CLEAR) begin
			mem_we    = 1'b1;
			mem_waddr = cnt_q[AW-1:0];
			mem_wdata = '0;
		end else if (accept && (opcode == tlsm_pkg::OP_RECORD) && new_qual) begin
			mem_we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			ring_mem[mem_waddr] <= mem_wdata;
		end
		rd_q <= ring_mem[cnt_q[AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_elapsed_q <= tlsm_pkg::MIN_ELAPSED_RESET;
		end else if (cfg_wr_en) begin
			min_elapsed_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= tlsm_pkg::ST_CLEAR;
			cnt_q     <= '0;
			rd_vld_q  <= 1'b0;
			wptr_q    <= '0;
			sum_q     <= '0;
			last_q    <= '0;
			wavg_q    <= '0;
			wmax_q    <= '0;
			pmax_q    <= '0;
			ptotal_q  <= '0;
			pcount_q  <= '0;
			pv_q      <= 1'b0;
			pavg_q    <= '0;
			ppk_q     <= '0;
			div_win_q <= 1'b0;
			div_cnt_q <= '0;
			rem_q     <= '0;
			quo_q     <= '0;
			dvs_q     <= '0;
			out_valid <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				out_valid <= 1'b0;
			end
			rd_vld_q <= 1'b0;
			case (state_q)
				tlsm_pkg::ST_CLEAR: begin
					if (cnt_q == CW'(WINDOW_DEPTH - 1)) begin
						cnt_q   <= '0;
						state_q <= tlsm_pkg::ST_IDLE;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				tlsm_pkg::ST_IDLE: begin
					if (accept) begin
						pv_q    <= 1'b0;
						pavg_q  <= '0;
						ppk_q   <= '0;
						state_q <= tlsm_pkg::ST_PUSH;
						case (opcode)
							tlsm_pkg::OP_RECORD: begin
								last_q <= elapsed;
								if (new_qual) begin
									if (wptr_q == AW'(WINDOW_DEPTH - 1)) begin
										wptr_q <= '0;
									end else begin
										wptr_q <= wptr_q + 1'b1;
									end
									cnt_q   <= '0;
									sum_q   <= '0;
									wmax_q  <= '0;
									state_q <= tlsm_pkg::ST_SCAN;
								end
							end
							tlsm_pkg::OP_ACCUMULATE: begin
								if (last_qual) begin
									if (last_q > pmax_q) begin
										pmax_q <= last_q;
									end
									ptotal_q <= ptotal_q + last_q;
									pcount_q <= pcount_q + 1'b1;
								end
							end
							tlsm_pkg::OP_FLUSH: begin
								if (pcount_q != '0) begin
									div_win_q <= 1'b0;
									div_cnt_q <= '0;
									rem_q     <= '0;
									quo_q     <= SW'(ptotal_q);
									dvs_q     <= pcount_q;
									state_q   <= tlsm_pkg::ST_DIV;
								end
							end
							default: begin
							end
						endcase
					end
				end
				tlsm_pkg::ST_SCAN: begin
					if (cnt_q != CW'(WINDOW_DEPTH)) begin
						cnt_q    <= cnt_q + 1'b1;
						rd_vld_q <= 1'b1;
					end
					if (rd_vld_q) begin
						sum_q <= sum_q + SW'(rd_q);
						if (rd_q > wmax_q) begin
							wmax_q <= rd_q;
						end
					end
					if ((cnt_q == CW'(WINDOW_DEPTH)) && !rd_vld_q) begin
						cnt_q <= '0;
						if (DEPTH_POW2) begin
							wavg_q  <= sum_q[SW-1:AW];
							state_q <= tlsm_pkg::ST_PUSH;
						end else begin
							div_win_q <= 1'b1;
							div_cnt_q <= '0;
							rem_q     <= '0;
							quo_q     <= sum_q;
							dvs_q     <= TW'(WINDOW_DEPTH);
							state_q   <= tlsm_pkg::ST_DIV;
						end
					end
				end
				tlsm_pkg::ST_DIV: begin
					rem_q <= div_ge ? div_diff[TW-1:0] : div_shift[TW-1:0];
					quo_q <= {quo_q[SW-2:0], div_ge};
					div_cnt_q <= div_cnt_q + 1'b1;
					if (div_cnt_q == DCW'(SW - 1)) begin
						state_q <= tlsm_pkg::ST_FIN;
					end
				end
				tlsm_pkg::ST_FIN: begin
					if (div_win_q) begin
						wavg_q <= quo_q[TW-1:0];
					end else begin
						pv_q     <= 1'b1;
						pavg_q   <= quo_q[TW-1:0];
						ppk_q    <= pmax_q;
						pmax_q   <= '0;
						ptotal_q <= '0;
						pcount_q <= '0;
					end
					state_q <= tlsm_pkg::ST_PUSH;
				end
				tlsm_pkg::ST_PUSH: begin
					if (out_free) begin
						out_valid <= 1'b1;
						state_q   <= tlsm_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= tlsm_pkg::ST_IDLE;
				end
			endcase
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if ((state_q == tlsm_pkg::ST_PUSH) && out_free) begin
			last_elapsed   <= last_q;
			window_average <= wavg_q;
			window_peak    <= wmax_q;
			period_valid   <= pv_q;
			period_average <= pavg_q;
			period_peak    <= ppk_q;
		end
	end

endmodule
